>>> design/point_line_distance_2d_defines.svh
// shared assertion macros
`ifndef POINT_LINE_DISTANCE_2D_DEFINES_SVH
`define POINT_LINE_DISTANCE_2D_DEFINES_SVH

// property that holds at every clock edge out of reset
`define PLD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// property that holds in the cycle after a condition
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pld_pkg.sv
package pld_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 26;
  localparam int DW         = COORD_BITS + 1;
  localparam int LW         = 2 * DW;
  localparam int HW         = DW;
  localparam int RW         = LW / 2;
  localparam int MXW        = (RW > DIST_BITS) ? RW : DIST_BITS;
  localparam int IN_W       = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((DIST_BITS + 7) / 8) * 8;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [2*LW-1:0] dividend;
    logic [LW-1:0]   divisor;
    logic            degen;
  } pld_item_t;

endpackage

>>> design/pld_front.sv
module pld_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [pld_pkg::IN_W-1:0] in_data,
  input  logic                  in_func,
  output logic                  push,
  input  logic                  q_ready,
  output pld_pkg::pld_item_t    item
);
  import pld_pkg::*;

  localparam int C = COORD_BITS;

  logic en;
  logic v1, v2, v3, v4, v5;
  logic f1, f2, f3, f4;
  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [LW-1:0] sqx, sqy, pa, pb;
  logic [LW-1:0] len2_3, dmag, len2_4;
  logic [LW-1:0] hh, hl, ll;
  logic signed [LW-1:0] det;
  logic [LW-1:0] dmag_next;
  logic [HW-1:0] dhi, dlo;
  logic [2*LW-1:0] sqv;
  pld_item_t item_next;
  logic [C-1:0] ax, ay, bx, by, px, py;

  assign en = !(v5 && !q_ready);
  assign in_ready = en;
  assign push = v5 && q_ready;

  assign ax = in_data[C-1:0];
  assign ay = in_data[2*C-1:C];
  assign bx = in_data[3*C-1:2*C];
  assign by = in_data[4*C-1:3*C];
  assign px = in_data[5*C-1:4*C];
  assign py = in_data[6*C-1:5*C];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign det = pa - pb;
  assign dmag_next = det[LW-1] ? LW'(-det) : LW'(det);
  assign dhi = dmag[LW-1:HW];
  assign dlo = dmag[HW-1:0];
  assign sqv = {hh, ll} + ((2*LW)'(hl) << (HW + 1));

  always_comb begin
    item_next.degen = 1'b0;
    item_next.divisor = LW'(1);
    if (!f4) begin
      item_next.dividend = (2*LW)'(len2_4);
    end else if (len2_4 == '0) begin
      item_next.dividend = '0;
      item_next.degen = 1'b1;
    end else begin
      item_next.dividend = sqv;
      item_next.divisor = len2_4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // differences
      dx <= {ax[C-1], ax} - {bx[C-1], bx};
      dy <= {ay[C-1], ay} - {by[C-1], by};
      ex <= {px[C-1], px} - {bx[C-1], bx};
      ey <= {py[C-1], py} - {by[C-1], by};
      f1 <= in_func;
      // products
      sqx <= dx * dx;
      sqy <= dy * dy;
      pa <= dx * ey;
      pb <= dy * ex;
      f2 <= f1;
      // squared length and cross product magnitude
      len2_3 <= LW'($unsigned(sqx) + $unsigned(sqy));
      dmag <= dmag_next;
      f3 <= f2;
      // partial products of det squared
      hh <= dhi * dhi;
      hl <= dhi * dlo;
      ll <= dlo * dlo;
      len2_4 <= len2_3;
      f4 <= f3;
      item <= item_next;
    end
  end

endmodule

>>> design/pld_queue.sv
`include "point_line_distance_2d_defines.svh"

module pld_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pld_pkg::pld_item_t wr_item,
  output logic               q_ready,
  input  logic               pop,
  output logic               q_valid,
  output pld_pkg::pld_item_t rd_item
);
  import pld_pkg::*;

  pld_item_t mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0] count;

  assign q_ready = count != (Q_AW+1)'(Q_DEPTH);
  assign q_valid = count != '0;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  `PLD_ASSERT(a_no_overflow, !(push && !q_ready), "queue push while full")
  `PLD_ASSERT(a_no_underflow, !(pop && !q_valid), "queue pop while empty")
  `PLD_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(count), "queue count moved")
  `PLD_ASSERT(a_ptr_match, (count == '0 || count == (Q_AW+1)'(Q_DEPTH)) == (wr_ptr == rd_ptr),
              "queue pointers disagree with count")

endmodule

>>> design/pld_back.sv
module pld_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pld_pkg::pld_item_t rd_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [pld_pkg::DIST_BITS-1:0] dist_res,
  output logic               degenerate
);
  import pld_pkg::*;

  logic en;

  logic [LW-1:0] drem [LW];
  logic [LW-1:0] dquo [LW];
  logic [LW-1:0] dlow [LW];
  logic [LW-1:0] ddiv [LW];
  logic          ddeg [LW];
  logic          dv   [LW];

  logic [RW+1:0] sr   [RW];
  logic [RW-1:0] sq   [RW];
  logic [LW-1:0] sn   [RW];
  logic          sdeg [RW];
  logic          sv   [RW];

  logic [MXW-1:0] root_ext;

  assign en = !out_valid || out_ready;
  assign pop = en && q_valid;

  genvar i;
  generate
    for (i = 0; i < LW; i++) begin : g_div
      logic [LW-1:0] prem, pquo, plow, pdiv;
      logic          pdeg, pv, ge;
      logic [LW:0]   t;
      if (i == 0) begin : g_first
        assign prem = rd_item.dividend[2*LW-1:LW];
        assign plow = rd_item.dividend[LW-1:0];
        assign pquo = '0;
        assign pdiv = rd_item.divisor;
        assign pdeg = rd_item.degen;
        assign pv   = pop;
      end else begin : g_rest
        assign prem = drem[i-1];
        assign plow = dlow[i-1];
        assign pquo = dquo[i-1];
        assign pdiv = ddiv[i-1];
        assign pdeg = ddeg[i-1];
        assign pv   = dv[i-1];
      end
      assign t  = {prem, plow[LW-1]};
      assign ge = t >= {1'b0, pdiv};
      always_ff @(posedge clk) begin
        if (rst) begin
          dv[i] <= 1'b0;
        end else if (en) begin
          dv[i] <= pv;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          drem[i] <= ge ? LW'(t - {1'b0, pdiv}) : LW'(t);
          dquo[i] <= {pquo[LW-2:0], ge};
          dlow[i] <= {plow[LW-2:0], 1'b0};
          ddiv[i] <= pdiv;
          ddeg[i] <= pdeg;
        end
      end
    end

    for (i = 0; i < RW; i++) begin : g_sqrt
      logic [RW+1:0] pr;
      logic [RW-1:0] pq;
      logic [LW-1:0] pn;
      logic          pdeg, pv, ge;
      logic [RW+3:0] t, trial;
      if (i == 0) begin : g_first
        assign pr   = '0;
        assign pq   = '0;
        assign pn   = dquo[LW-1];
        assign pdeg = ddeg[LW-1];
        assign pv   = dv[LW-1];
      end else begin : g_rest
        assign pr   = sr[i-1];
        assign pq   = sq[i-1];
        assign pn   = sn[i-1];
        assign pdeg = sdeg[i-1];
        assign pv   = sv[i-1];
      end
      assign t     = {pr, pn[LW-1:LW-2]};
      assign trial = {2'b00, pq, 2'b01};
      assign ge    = t >= trial;
      always_ff @(posedge clk) begin
        if (rst) begin
          sv[i] <= 1'b0;
        end else if (en) begin
          sv[i] <= pv;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sr[i]   <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
          sq[i]   <= {pq[RW-2:0], ge};
          sn[i]   <= {pn[LW-3:0], 2'b00};
          sdeg[i] <= pdeg;
        end
      end
    end
  endgenerate

  assign out_valid = sv[RW-1];
  assign root_ext = MXW'(sq[RW-1]);
  assign degenerate = sdeg[RW-1];
  assign dist_res = (sdeg[RW-1] || root_ext > MXW'(DIST_MAX)) ? DIST_MAX
                                                              : DIST_BITS'(root_ext);

endmodule

>>> design/point_line_distance_2d.sv
// 2d distance unit, fixed point, one result item per input item
// input channel s_*: tuser holds the mode (0 distance a to b, 1 distance p to
// line ab); tdata holds ax, ay, bx, by, px, py, 24-bit signed each
// output channel m_*: tdata holds the floored distance in its low 26 bits,
// tuser flags a degenerate line (mode 1 with a equal to b, distance saturated)
// a new item is taken every cycle while the front is not stalled; an item
// passes 5 front stages that square, take the cross product and square its
// magnitude, a 4-entry queue, then 50 restoring divide steps and 25 square
// root steps, one pipeline stage each
// the front stalls only when the queue is full, the back only when its
// output item is held by a low m_tready; results are never lost or repeated
// rst (synchronous, active high) empties all stages and the queue; in-flight
// items are dropped
module point_line_distance_2d (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [pld_pkg::IN_W-1:0]   s_tdata,  // ax, ay, bx, by, px, py
  input  logic [0:0]                 s_tuser,  // func
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [pld_pkg::OUT_W-1:0]  m_tdata,  // dist_res, zero fill
  output logic [0:0]                 m_tuser   // degenerate
);
  import pld_pkg::*;

  logic push, q_ready, q_valid, pop;
  pld_item_t wr_item, rd_item;
  logic [DIST_BITS-1:0] dist_res;
  logic degenerate;

  pld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_func  (s_tuser[0]),
    .push     (push),
    .q_ready  (q_ready),
    .item     (wr_item)
  );

  pld_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_item (rd_item)
  );

  pld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .rd_item    (rd_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .dist_res   (dist_res),
    .degenerate (degenerate)
  );

  assign m_tdata = OUT_W'(dist_res);
  assign m_tuser = degenerate;

endmodule
